/* rtl/core/dpq_pkg.sv */
// Shared types, command codes and defaults for the double-ended priority queue.
package dpq_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_POP_MIN = 2'd1;
  localparam logic [1:0] CMD_POP_MAX = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } dpq_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               was_empty;
    logic               was_full;
    logic [6:0]         entry_count;
  } dpq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins_start;
    logic pop_min;
    logic pop_max;
    logic shift;
    logic place;
    logic res_set;
    logic res_pop;
    logic res_empty;
    logic res_full;
    logic load_out;
  } dpq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic greater;
    logic idx_one;
    logic out_free;
  } dpq_stat_t;

endpackage

/* rtl/core/double_ended_priority_queue.sv */
// Double-ended priority queue top level: controller plus sorted-store datapath.
//
// Holds up to DEPTH signed 32-bit values in ascending order in a circular
// one-write/one-read memory. Each transaction (insert, pop-min, pop-max or an
// unused code) returns exactly one result. A pop goes straight from acceptance
// to the response state. An insert first walks down the store, moving each
// stored value larger than the new one up a slot, one entry per cycle
// through the memory's single write port. Rejected commands (full insert,
// empty pop, unused code) also go straight to the response state. One
// transaction is worked at a time, and a new one is taken while the previous
// result still waits at the output. No clearing pass follows reset.
module double_ended_priority_queue #(
  parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpq_pkg::dpq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dpq_pkg::dpq_out_t out_data
);

  dpq_pkg::dpq_ctrl_t ctrl;
  dpq_pkg::dpq_stat_t stat;

  dpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_data.cmd),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_value  (in_data.value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/dpq_ctrl.sv */
// Controller state machine: decodes commands and sequences the insert walk.
module dpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  dpq_pkg::dpq_stat_t stat,
  output dpq_pkg::dpq_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PLACE,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.res_set = 1'b1;
          state_nxt    = ST_RESP;
          unique case (in_cmd)
            dpq_pkg::CMD_INSERT: begin
              if (stat.count_full) begin
                ctrl.res_full = 1'b1;
              end else begin
                ctrl.ins_start = 1'b1;
                state_nxt = stat.count_zero ? ST_INS_PLACE : ST_INS_CMP;
              end
            end
            dpq_pkg::CMD_POP_MIN: begin
              if (stat.count_zero) begin
                ctrl.res_empty = 1'b1;
              end else begin
                ctrl.pop_min = 1'b1;
                ctrl.res_pop = 1'b1;
              end
            end
            dpq_pkg::CMD_POP_MAX: begin
              if (stat.count_zero) begin
                ctrl.res_empty = 1'b1;
              end else begin
                ctrl.pop_max = 1'b1;
                ctrl.res_pop = 1'b1;
              end
            end
            default: begin
              // unused command: report the count only
            end
          endcase
        end
      end
      ST_INS_CMP: begin
        if (stat.greater) begin
          ctrl.shift = 1'b1;
          if (stat.idx_one) begin
            state_nxt = ST_INS_PLACE;
          end
        end else begin
          ctrl.place = 1'b1;
          state_nxt  = ST_RESP;
        end
      end
      ST_INS_PLACE: begin
        ctrl.place = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/dpq_datapath.sv */
// Datapath: circular sorted store, head and count, insert walk pointers, result register.
module dpq_datapath #(
  parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_pkg::dpq_ctrl_t ctrl,
  output dpq_pkg::dpq_stat_t stat,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output dpq_pkg::dpq_out_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0] mem [DEPTH];

  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rp_r;
  logic [AW-1:0]      idx_r;
  logic signed [31:0] val_r;
  logic signed [31:0] rdata_r;
  logic               res_pop_r;
  logic               res_empty_r;
  logic               res_full_r;
  logic               out_valid_r;
  dpq_pkg::dpq_out_t  out_data_r;

  logic [CW:0]   tail_sum;
  logic [CW:0]   last_sum;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] raddr;
  logic          re;
  logic          we;
  logic [31:0]   wdata;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
    ptr_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
    ptr_dec = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  // Physical slot one past the largest value, and the slot of the largest value.
  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign last_sum  = tail_sum - (CW+1)'(1);
  assign tail_addr = AW'((tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum);
  assign last_addr = AW'((last_sum >= (CW+1)'(DEPTH)) ? last_sum - (CW+1)'(DEPTH) : last_sum);

  always_comb begin
    raddr = ptr_dec(rp_r);
    re    = 1'b0;
    priority if (ctrl.pop_min) begin
      raddr = head_r;
      re    = 1'b1;
    end else if (ctrl.pop_max) begin
      raddr = last_addr;
      re    = 1'b1;
    end else if (ctrl.ins_start) begin
      raddr = ptr_dec(tail_addr);
      re    = 1'b1;
    end else if (ctrl.shift) begin
      raddr = ptr_dec(rp_r);
      re    = !stat.idx_one;
    end
  end

  assign we    = ctrl.shift || ctrl.place;
  assign wdata = ctrl.shift ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp_r] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.ins_start) begin
        count_r <= count_r + CW'(1);
      end else if (ctrl.pop_min) begin
        count_r <= count_r - CW'(1);
        head_r  <= ptr_inc(head_r);
      end else if (ctrl.pop_max) begin
        count_r <= count_r - CW'(1);
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_start) begin
      val_r <= in_value;
      wp_r  <= tail_addr;
      rp_r  <= ptr_dec(tail_addr);
      idx_r <= AW'(count_r);
    end else if (ctrl.shift) begin
      // move the hole down one slot
      wp_r  <= rp_r;
      rp_r  <= ptr_dec(rp_r);
      idx_r <= idx_r - AW'(1);
    end
    if (ctrl.res_set) begin
      res_pop_r   <= ctrl.res_pop;
      res_empty_r <= ctrl.res_empty;
      res_full_r  <= ctrl.res_full;
    end
    if (ctrl.load_out) begin
      out_data_r.popped_value <= res_pop_r ? rdata_r : 32'sd0;
      out_data_r.was_empty    <= res_empty_r;
      out_data_r.was_full     <= res_full_r;
      out_data_r.entry_count  <= 7'(count_r);
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.count_full = (count_r == CW'(DEPTH));
  assign stat.greater    = (rdata_r > val_r);
  assign stat.idx_one    = (idx_r == AW'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !ctrl.ins_start && !ctrl.pop_min && !ctrl.pop_max) |=> $stable(count_r))
    else $error("fill count changed without a transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |-> (idx_r != '0))
    else $error("shift past bottom of queue");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the double-ended priority queue: directed, fill/drain and random.
`timescale 1ns / 100ps

module tb;
  import dpq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dpq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dpq_out_t out_data;

  // Shadow of the sorted store and the results still owed by the block
  logic signed [31:0] shadow_sorted[$];
  dpq_out_t           pending_results[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full_rejects = 0;
  int n_empty_pops = 0;
  int peak_fill = 0;

  double_ended_priority_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Apply one command to the shadow store and return the result it must produce
  function automatic dpq_out_t predict_result(input dpq_in_t item);
    dpq_out_t           r;
    logic signed [31:0] v;
    int                 pos;
    r = '0;
    v = item.value;
    case (item.cmd)
      CMD_INSERT: begin
        if (shadow_sorted.size() >= DEPTH) begin
          r.was_full = 1'b1;
        end else begin
          pos = shadow_sorted.size();
          while (pos > 0 && shadow_sorted[pos-1] > v) pos--;
          shadow_sorted.insert(pos, v);
        end
      end
      CMD_POP_MIN, CMD_POP_MAX: begin
        if (shadow_sorted.size() == 0) begin
          r.was_empty = 1'b1;
        end else if (item.cmd == CMD_POP_MIN) begin
          r.popped_value = shadow_sorted.pop_front();
        end else begin
          r.popped_value = shadow_sorted.pop_back();
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_sorted.size());
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    dpq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: value %0d empty %b full %b count %0d",
                   $realtime, out_data.popped_value, out_data.was_empty,
                   out_data.was_full, out_data.entry_count);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_data.popped_value !== want.popped_value ||
            out_data.was_empty !== want.was_empty ||
            out_data.was_full !== want.was_full ||
            out_data.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected value %0d empty %b full %b count %0d, got value %0d empty %b full %b count %0d",
                     $realtime, want.popped_value, want.was_empty, want.was_full,
                     want.entry_count, out_data.popped_value, out_data.was_empty,
                     out_data.was_full, out_data.entry_count);
        end
      end
    end
  end

  // Present one transaction, idling first at the current rate, and predict it on acceptance
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
    dpq_in_t  item;
    dpq_out_t res;
    item.cmd = cmd;
    item.value = val;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= dpq_in_t'({$urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    res = predict_result(item);
    pending_results.push_back(res);
    n_sent++;
    if (res.was_full) n_full_rejects++;
    if (res.was_empty) n_empty_pops++;
    if (shadow_sorted.size() > peak_fill) peak_fill = shadow_sorted.size();
  endtask

  // Hold the sender off until the block has delivered everything owed
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      5: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      6, 7: return $signed(32'($urandom_range(16))) - 32'sd8;
      8: return VAL_MAX - $signed(32'($urandom_range(15)));
      9: return VAL_MIN + $signed(32'($urandom_range(15)));
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_cmd(input int ins_pct);
    int roll = $urandom_range(99);
    if (roll < 3) return CMD_NOP;
    if ($urandom_range(99) < ins_pct) return CMD_INSERT;
    return $urandom_range(1) ? CMD_POP_MAX : CMD_POP_MIN;
  endfunction

  task automatic test_directed();
    in_idle_pct = 0;
    out_stall_pct = 0;
    // pops and the unused code on an empty queue
    send_item(CMD_POP_MIN, $signed($urandom));
    send_item(CMD_POP_MAX, $signed($urandom));
    send_item(CMD_NOP, '0);
    // extremes, zero, the sign boundary and duplicates
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, 32'sd0);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd1);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_NOP, -32'sd1);
    send_item(CMD_POP_MAX, -32'sd1);
    send_item(CMD_POP_MAX, '0);
    send_item(CMD_POP_MIN, VAL_MAX);
    send_item(CMD_POP_MIN, VAL_MIN);
    send_item(CMD_INSERT, 32'sh5555_5555);
    send_item(CMD_INSERT, 32'shAAAA_AAAA);
    send_item(CMD_POP_MIN, '0);
    send_item(CMD_POP_MAX, '0);
    send_item(CMD_POP_MAX, '0);
    send_item(CMD_POP_MIN, '0);
    send_item(CMD_POP_MIN, '0);
    send_item(CMD_POP_MIN, '0);
  endtask

  task automatic test_full_and_empty();
    in_idle_pct = 0;
    out_stall_pct = 0;
    // descending inserts walk past every stored value
    for (int k = 0; k < DEPTH / 2; k++) send_item(CMD_INSERT, VAL_MAX - 32'(k));
    while (shadow_sorted.size() < DEPTH) send_item(CMD_INSERT, pick_value());
    wait_results_drained();
    send_item(CMD_INSERT, pick_value());
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_NOP, pick_value());
    send_item(CMD_POP_MAX, '0);
    send_item(CMD_POP_MIN, '0);
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, 32'sd0);
    while (shadow_sorted.size() > 0)
      send_item($urandom_range(1) ? CMD_POP_MAX : CMD_POP_MIN, pick_value());
    send_item(CMD_POP_MAX, '0);
    send_item(CMD_POP_MIN, '0);
  endtask

  task automatic test_random(input int idle_p, input int stall_p, input int n_items);
    int left;
    int burst;
    int ins_pct;
    in_idle_pct = idle_p;
    out_stall_pct = stall_p;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(3))
        0: ins_pct = 50;
        1: ins_pct = 85;
        2: ins_pct = 15;
        default: ins_pct = (shadow_sorted.size() > DEPTH / 2) ? 30 : 70;
      endcase
      if ($urandom_range(9) == 0) wait_results_drained();
      for (int k = 0; k < burst && left > 0; k++) begin
        send_item(pick_cmd(ins_pct), pick_value());
        left--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_and_empty();
    test_random(0, 0, 150);
    test_random(75, 0, 150);
    test_random(0, 75, 150);
    test_random(36, 36, 150);
    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d transactions, %0d results compared, %0d mismatches.",
             n_sent, n_checked, mismatches);
    $display("Hit %0d inserts into a full queue, %0d pops on empty, peak fill %0d of %0d.",
             n_full_rejects, n_empty_pops, peak_fill, DEPTH);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
